>>> design/packbits_run_length_decoder_macros.svh
// ----------------------------------------------------------------------------
// PackBits run-length decoder assertion macros
// Concurrent assertion helpers, compiled out under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_RUN_LENGTH_DECODER_MACROS_SVH
`define PACKBITS_RUN_LENGTH_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PBRLD_ASSERT_IMPLIES(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("pbrld assertion failed");

`define PBRLD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("pbrld assertion failed");

`else

`define PBRLD_ASSERT_IMPLIES(label, clock, reset, ante, cons)

`define PBRLD_ASSERT_NEXT(label, clock, reset, ante, cons)

`endif

`endif

>>> design/pbrld_pkg.sv
// ----------------------------------------------------------------------------
// PackBits run-length decoder package
// Counter widths, register indexes, header codes and the decode phase type.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrld_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int CFG_WIDTH   = 24;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_WIDTH  = 3;

  localparam logic REG_OUTPUT_LIMIT = 1'b0;
  localparam logic REG_HEADER_LIMIT = 1'b1;

  localparam logic [7:0] HDR_NOOP = 8'h80;
  localparam logic [8:0] RUN_BASE = 9'd257;

  typedef enum logic [3:0] {
    PH_FRESH   = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_LITERAL = 4'b0100,
    PH_RUNVAL  = 4'b1000
  } phase_t;

endpackage

`default_nettype wire

>>> design/packbits_run_length_decoder.sv
// ----------------------------------------------------------------------------
// PackBits run-length decoder
// Decodes one compressed byte per word into literal and run results, with
// output and header budgets set through an APB-style register port.
// ----------------------------------------------------------------------------
// Takes one source byte per clock and returns at most one result per byte;
// an accepted byte's result is written to the result register as the byte is
// taken, and a new byte is accepted every cycle while the result register is
// empty or being drained. The rate is set by the combinational phase and
// budget update. The budgets are loaded from output_limit and header_limit
// at the first byte of each decode, so register writes take effect at the
// next decode. There is no clearing pass after reset.
`default_nettype none

`include "packbits_run_length_decoder_macros.svh"

module packbits_run_length_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pbrld_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [pbrld_pkg::DATA_WIDTH-1:0] pwdata,
  output logic      [pbrld_pkg::DATA_WIDTH-1:0] prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      source_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [7:0]                      out_value,
  output logic      [7:0]                      repeat_count,
  output logic                                 last,
  output logic                                 short_output
);
  import pbrld_pkg::*;

  logic [CFG_WIDTH-1:0]   output_limit;
  logic [CFG_WIDTH-1:0]   header_limit;
  phase_t                 phase;
  phase_t                 phase_next;
  logic [7:0]             literal_left;
  logic [7:0]             literal_left_next;
  logic [7:0]             run_length;
  logic [7:0]             run_length_next;
  logic [COUNT_WIDTH-1:0] output_left;
  logic [COUNT_WIDTH-1:0] output_left_next;
  logic [COUNT_WIDTH-1:0] headers_left;
  logic [COUNT_WIDTH-1:0] headers_left_next;

  logic                   cfg_write;
  logic                   in_fire;
  logic                   emit;
  logic [7:0]             res_value;
  logic [7:0]             res_rep;
  logic                   res_last;
  logic                   res_short;

  logic [COUNT_WIDTH-1:0] ol_cur;
  logic [COUNT_WIDTH-1:0] hl_cur;
  logic [COUNT_WIDTH-1:0] hl_dec;
  logic [7:0]             run_cnt;
  logic                   do_finish;
  logic                   fin_more;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    case (paddr[2])
      REG_OUTPUT_LIMIT: prdata = DATA_WIDTH'(output_limit);
      REG_HEADER_LIMIT: prdata = DATA_WIDTH'(header_limit);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= '0;
      header_limit <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_OUTPUT_LIMIT: output_limit <= pwdata[CFG_WIDTH-1:0];
        REG_HEADER_LIMIT: header_limit <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ol_cur = (phase == PH_FRESH) ? COUNT_WIDTH'(output_limit) : output_left;
    hl_cur = (phase == PH_FRESH) ? COUNT_WIDTH'(header_limit) : headers_left;
    hl_dec = hl_cur - COUNT_WIDTH'(1);
    run_cnt = (COUNT_WIDTH'(run_length) > ol_cur) ? ol_cur[7:0] : run_length;

    phase_next        = phase;
    literal_left_next = literal_left;
    run_length_next   = run_length;
    output_left_next  = ol_cur;
    headers_left_next = hl_cur;
    emit              = 1'b0;
    res_value         = source_byte;
    res_rep           = 8'd1;
    res_last          = 1'b0;
    res_short         = 1'b0;
    do_finish         = 1'b0;
    fin_more          = 1'b0;

    case (phase)
      PH_FRESH, PH_HEADER: begin
        if (phase == PH_FRESH && (ol_cur == '0 || hl_cur == '0)) begin
          literal_left_next = '0;
          run_length_next   = '0;
          emit              = 1'b1;
          res_value         = '0;
          res_rep           = '0;
          res_last          = 1'b1;
          res_short         = (ol_cur != '0);
          phase_next        = PH_FRESH;
        end else begin
          headers_left_next = hl_dec;
          if (phase == PH_FRESH) begin
            literal_left_next = '0;
            run_length_next   = '0;
          end
          if (!source_byte[7]) begin
            literal_left_next = source_byte + 8'd1;
            phase_next        = PH_LITERAL;
          end else if (source_byte == HDR_NOOP) begin
            if (hl_dec == '0) begin
              emit       = 1'b1;
              res_value  = '0;
              res_rep    = '0;
              res_last   = 1'b1;
              res_short  = 1'b1;
              phase_next = PH_FRESH;
            end else begin
              phase_next = PH_HEADER;
            end
          end else begin
            run_length_next = 8'(RUN_BASE - {1'b0, source_byte});
            phase_next      = PH_RUNVAL;
          end
        end
      end
      PH_LITERAL: begin
        output_left_next  = ol_cur - COUNT_WIDTH'(1);
        literal_left_next = literal_left - 8'd1;
        res_rep           = 8'd1;
        fin_more          = (literal_left_next != '0);
        do_finish         = 1'b1;
      end
      PH_RUNVAL: begin
        output_left_next = ol_cur - COUNT_WIDTH'(run_cnt);
        run_length_next  = '0;
        res_rep          = run_cnt;
        fin_more         = 1'b0;
        do_finish        = 1'b1;
      end
      default: begin
        phase_next = PH_FRESH;
      end
    endcase

    if (do_finish) begin
      emit = 1'b1;
      if (output_left_next == '0) begin
        phase_next = PH_FRESH;
        res_last   = 1'b1;
        res_short  = 1'b0;
      end else if (!fin_more && hl_cur == '0) begin
        phase_next = PH_FRESH;
        res_last   = 1'b1;
        res_short  = 1'b1;
      end else begin
        phase_next = fin_more ? PH_LITERAL : PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FRESH;
      literal_left <= '0;
      run_length   <= '0;
      output_left  <= '0;
      headers_left <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      literal_left <= literal_left_next;
      run_length   <= run_length_next;
      output_left  <= output_left_next;
      headers_left <= headers_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_value    <= res_value;
      repeat_count <= res_rep;
      last         <= res_last;
      short_output <= res_short;
    end
  end

  `PBRLD_ASSERT_IMPLIES(a_short_only_on_last, clk, rst, out_valid && short_output, last)
  `PBRLD_ASSERT_IMPLIES(a_zero_rep_only_on_last, clk, rst, out_valid && repeat_count == 8'd0,
                        last)
  `PBRLD_ASSERT_IMPLIES(a_rep_in_range, clk, rst, out_valid, repeat_count <= 8'd128)
  `PBRLD_ASSERT_IMPLIES(a_literal_budget, clk, rst, phase == PH_LITERAL,
                        literal_left != 8'd0 && output_left != '0)
  `PBRLD_ASSERT_NEXT(a_drain_clears, clk, rst, out_valid && out_ready && !(in_fire && emit),
                     !out_valid)

endmodule

`default_nettype wire
